>>> sv/min_max_decimator_core_assert.svh
// assertion macros for the min/max decimator
// used by min_max_decimator_core, no other dependencies
`ifndef MIN_MAX_DECIMATOR_CORE_ASSERT_SVH
`define MIN_MAX_DECIMATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, masked while reset is high
`define MMD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define MMD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MMD_ASSERT(label, clk, rst, prop, msg)
`define MMD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> sv/mmd_pkg.sv
// shared types and constants for the min/max decimator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mmd_pkg;

   // size limits of one trace
   localparam int MAX_SAMPLES = 65536;
   localparam int MAX_COLUMNS = 4096;

   // field widths
   localparam int SAMPLE_W   = 16;
   localparam int SCOUNT_W   = 17;
   localparam int CCOUNT_W   = 13;
   localparam int COLUMN_W   = 12;
   localparam int YPOS_W     = 16;
   localparam int YCFG_W     = 24;
   localparam int PROD_W     = 29;
   localparam int MUL_W      = SAMPLE_W + YCFG_W;
   localparam int RSP_DATA_W = 32;

   // register indexes of the configuration port
   localparam logic [1:0] REG_SAMPLE_COUNT = 2'd0;
   localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;
   localparam logic [1:0] REG_Y_BASE       = 2'd2;
   localparam logic [1:0] REG_Y_GAIN       = 2'd3;

   // reset values of the size registers
   localparam logic [SCOUNT_W-1:0] SAMPLE_COUNT_RST = 17'd65536;
   localparam logic [CCOUNT_W-1:0] COLUMN_COUNT_RST = 13'd256;

   // one closed column: both points in output order
   typedef struct packed {
      logic [COLUMN_W-1:0] column;
      logic [SAMPLE_W-1:0] first_value;
      logic [SAMPLE_W-1:0] second_value;
      logic                last;
   } pair_type;

endpackage

`default_nettype wire

>>> sv/min_max_decimator_core.sv
// Min/max decimator for a waveform thumbnail.
// Input stream req_*: one unsigned 16-bit trace sample per item.
// Output stream rsp_*: two points per pixel column, min and max in order of
// occurrence (max first when both sit on the same sample); tuser marks the
// second point of a pair, tlast the final point of the whole trace.
// Config port csr_*: sample_count, column_count, y_base, y_gain; writing a
// size register restarts the trace and holds req_tready low for one cycle.
// Path: after a column's last sample is taken, its points pass from the pair
// register through the multiply register to the output register, first point first.
// Throughput: one sample per cycle while columns span two or more samples and no
// stall comes from rsp_tready; with one sample per column, a sample waits for the
// last pair to leave, as the single output register drains one point per cycle.
// Reset: sizes return to 65536 samples and 256 columns, y mapping to zero,
// and the trace restarts at sample 0.
// Stall: a held rsp_tready fills the output, multiply and pair registers;
// samples that do not close a column are still taken, a closing one waits.
// depends on mmd_pkg, mmd_tracker, mmd_mapper, min_max_decimator_core_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "min_max_decimator_core_assert.svh"

module min_max_decimator_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // sample [15:0]
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [mmd_pkg::SAMPLE_W-1:0]    req_tdata,
   // column [11:0], y_pos [27:12], zero [31:28]
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [mmd_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // pair_last [0]
   output logic                                  rsp_tuser,
   // frame_last
   output logic                                  rsp_tlast,
   input  wire logic                             csr_we,
   input  wire logic [1:0]                       csr_addr,
   input  wire logic [mmd_pkg::YCFG_W-1:0]      csr_wdata
);

   logic [mmd_pkg::SCOUNT_W-1:0] sample_count_ff;
   logic [mmd_pkg::CCOUNT_W-1:0] column_count_ff;
   logic [mmd_pkg::YCFG_W-1:0]   y_base_ff;
   logic [mmd_pkg::YCFG_W-1:0]   y_gain_ff;
   logic                         restart_ff;

   logic                         pair_valid;
   logic                         pair_ready;
   mmd_pkg::pair_type            pair;
   logic [mmd_pkg::COLUMN_W-1:0] out_column;
   logic [mmd_pkg::YPOS_W-1:0]   out_y_pos;

   // configuration registers, size writes restart the trace
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= mmd_pkg::SAMPLE_COUNT_RST;
         column_count_ff <= mmd_pkg::COLUMN_COUNT_RST;
         y_base_ff       <= '0;
         y_gain_ff       <= '0;
         restart_ff      <= 1'b0;
      end else begin
         restart_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_addr)
               mmd_pkg::REG_SAMPLE_COUNT: begin
                  sample_count_ff <= csr_wdata[mmd_pkg::SCOUNT_W-1:0];
                  restart_ff      <= 1'b1;
               end
               mmd_pkg::REG_COLUMN_COUNT: begin
                  column_count_ff <= csr_wdata[mmd_pkg::CCOUNT_W-1:0];
                  restart_ff      <= 1'b1;
               end
               mmd_pkg::REG_Y_BASE: begin
                  y_base_ff <= csr_wdata;
               end
               mmd_pkg::REG_Y_GAIN: begin
                  y_gain_ff <= csr_wdata;
               end
               default: begin
                  restart_ff <= 1'b0;
               end
            endcase
         end
      end
   end

   // column tracking
   mmd_tracker u_tracker (
      .clock        (clock),
      .reset        (reset),
      .sample_count (sample_count_ff),
      .column_count (column_count_ff),
      .restart      (restart_ff),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_sample    (req_tdata),
      .pair_valid   (pair_valid),
      .pair_ready   (pair_ready),
      .pair         (pair)
   );

   // point serializer and y mapping
   mmd_mapper u_mapper (
      .clock          (clock),
      .reset          (reset),
      .y_base         (y_base_ff),
      .y_gain         (y_gain_ff),
      .pair_valid     (pair_valid),
      .pair_ready     (pair_ready),
      .pair           (pair),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_column     (out_column),
      .out_y_pos      (out_y_pos),
      .out_pair_last  (rsp_tuser),
      .out_frame_last (rsp_tlast)
   );

   assign rsp_tdata = {4'h0, out_y_pos, out_column};

   // checks
   `MMD_ASSERT(a_pair_has_room, clock, reset, pair_valid |-> pair_ready, "pair handed over without room")
   `MMD_ASSERT(a_frame_end_is_second, clock, reset, (rsp_tvalid && rsp_tlast) |-> rsp_tuser, "trace end on first point of a pair")
   `MMD_ASSERT(a_second_follows, clock, reset, (rsp_tvalid && rsp_tready && !rsp_tuser) |=> (rsp_tvalid && rsp_tuser && (rsp_tdata[11:0] == $past(rsp_tdata[11:0]))), "second point of a pair not ready next cycle")

endmodule

`default_nettype wire

>>> sv/mmd_tracker.sv
// column boundary tracking and running min/max per column
// depends on mmd_pkg
`timescale 1ns / 1ps
`default_nettype none

module mmd_tracker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [mmd_pkg::SCOUNT_W-1:0]  sample_count,
   input  wire logic [mmd_pkg::CCOUNT_W-1:0]  column_count,
   input  wire logic                           restart,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire logic [mmd_pkg::SAMPLE_W-1:0]  in_sample,
   output logic                                pair_valid,
   input  wire logic                           pair_ready,
   output mmd_pkg::pair_type                   pair
);

   logic [mmd_pkg::SCOUNT_W-1:0] n_eff;
   logic [mmd_pkg::CCOUNT_W-1:0] w_lim;
   logic [mmd_pkg::CCOUNT_W-1:0] w_eff;

   logic [mmd_pkg::SCOUNT_W-1:0] sidx_ff, sidx_in;
   logic [mmd_pkg::COLUMN_W-1:0] col_ff, col_in;
   logic [mmd_pkg::PROD_W-1:0]   sp_ff, sp_in;
   logic [mmd_pkg::PROD_W-1:0]   cp_ff, cp_in;
   logic [mmd_pkg::SAMPLE_W-1:0] maxv_ff, maxv_in;
   logic [mmd_pkg::SAMPLE_W-1:0] minv_ff, minv_in;
   logic [mmd_pkg::SCOUNT_W-1:0] maxp_ff, maxp_in;
   logic [mmd_pkg::SCOUNT_W-1:0] minp_ff, minp_in;

   logic accept;
   logic close_now;
   logic first_now;
   logic last_col;

   // effective trace sizes, every column gets at least one sample
   always_comb begin
      if (sample_count == '0) begin
         n_eff = mmd_pkg::SCOUNT_W'(1);
      end else if (sample_count > mmd_pkg::SCOUNT_W'(mmd_pkg::MAX_SAMPLES)) begin
         n_eff = mmd_pkg::SCOUNT_W'(mmd_pkg::MAX_SAMPLES);
      end else begin
         n_eff = sample_count;
      end
      if (column_count == '0) begin
         w_lim = mmd_pkg::CCOUNT_W'(1);
      end else if (column_count > mmd_pkg::CCOUNT_W'(mmd_pkg::MAX_COLUMNS)) begin
         w_lim = mmd_pkg::CCOUNT_W'(mmd_pkg::MAX_COLUMNS);
      end else begin
         w_lim = column_count;
      end
      if (mmd_pkg::SCOUNT_W'(w_lim) > n_eff) begin
         w_eff = n_eff[mmd_pkg::CCOUNT_W-1:0];
      end else begin
         w_eff = w_lim;
      end
   end

   // handshake: a closing item needs room for its pair
   assign close_now  = sp_ff >= cp_ff;
   assign first_now  = (sp_ff - mmd_pkg::PROD_W'(w_eff)) >= (cp_ff - mmd_pkg::PROD_W'(n_eff));
   assign last_col   = (mmd_pkg::CCOUNT_W'(col_ff) + mmd_pkg::CCOUNT_W'(1)) >= w_eff;
   assign in_ready   = !restart && (!close_now || pair_ready);
   assign accept     = in_valid && in_ready;
   assign pair_valid = accept && close_now;

   // running min/max including the current item
   always_comb begin
      maxv_in = maxv_ff;
      minv_in = minv_ff;
      maxp_in = maxp_ff;
      minp_in = minp_ff;
      priority if (first_now) begin
         maxv_in = in_sample;
         minv_in = in_sample;
         maxp_in = sidx_ff;
         minp_in = sidx_ff;
      end else if (in_sample > maxv_ff) begin
         maxv_in = in_sample;
         maxp_in = sidx_ff;
      end else if (in_sample < minv_ff) begin
         minv_in = in_sample;
         minp_in = sidx_ff;
      end
   end

   // pair in order of occurrence, max first on a tie
   always_comb begin
      pair.column = col_ff;
      pair.last   = last_col;
      if (minp_in < maxp_in) begin
         pair.first_value  = minv_in;
         pair.second_value = maxv_in;
      end else begin
         pair.first_value  = maxv_in;
         pair.second_value = minv_in;
      end
   end

   // position and boundary bookkeeping
   always_comb begin
      sidx_in = sidx_ff;
      col_in  = col_ff;
      sp_in   = sp_ff;
      cp_in   = cp_ff;
      if (restart || (accept && close_now && last_col)) begin
         sidx_in = '0;
         col_in  = '0;
         sp_in   = mmd_pkg::PROD_W'(w_eff);
         cp_in   = mmd_pkg::PROD_W'(n_eff);
      end else if (accept) begin
         sidx_in = sidx_ff + mmd_pkg::SCOUNT_W'(1);
         sp_in   = sp_ff + mmd_pkg::PROD_W'(w_eff);
         if (close_now) begin
            col_in = col_ff + mmd_pkg::COLUMN_W'(1);
            cp_in  = cp_ff + mmd_pkg::PROD_W'(n_eff);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sidx_ff <= '0;
         col_ff  <= '0;
         sp_ff   <= mmd_pkg::PROD_W'(mmd_pkg::COLUMN_COUNT_RST);
         cp_ff   <= mmd_pkg::PROD_W'(mmd_pkg::SAMPLE_COUNT_RST);
      end else begin
         sidx_ff <= sidx_in;
         col_ff  <= col_in;
         sp_ff   <= sp_in;
         cp_ff   <= cp_in;
      end
   end

   // extremes and their positions, only read after a column opens
   always_ff @(posedge clock) begin
      if (accept) begin
         maxv_ff <= maxv_in;
         minv_ff <= minv_in;
         maxp_ff <= maxp_in;
         minp_ff <= minp_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/mmd_mapper.sv
// pair holding register, point serializer and two-stage y mapping
// depends on mmd_pkg
`timescale 1ns / 1ps
`default_nettype none

module mmd_mapper (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [mmd_pkg::YCFG_W-1:0]   y_base,
   input  wire logic [mmd_pkg::YCFG_W-1:0]   y_gain,
   input  wire logic                          pair_valid,
   output logic                               pair_ready,
   input  wire mmd_pkg::pair_type             pair,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [mmd_pkg::COLUMN_W-1:0]      out_column,
   output logic [mmd_pkg::YPOS_W-1:0]        out_y_pos,
   output logic                               out_pair_last,
   output logic                               out_frame_last
);

   localparam int SUM_W = mmd_pkg::MUL_W + 2;
   localparam int Q_W   = SUM_W - 16;

   mmd_pkg::pair_type pair_ff;
   logic              full_ff;
   logic              half_ff;

   logic                          s1_valid_ff;
   logic [mmd_pkg::MUL_W-1:0]     s1_prod_ff;
   logic [mmd_pkg::COLUMN_W-1:0]  s1_column_ff;
   logic                          s1_pair_last_ff;
   logic                          s1_frame_last_ff;

   logic                          s2_valid_ff;
   logic [mmd_pkg::COLUMN_W-1:0]  s2_column_ff;
   logic [mmd_pkg::YPOS_W-1:0]    s2_y_ff, s2_y_in;
   logic                          s2_pair_last_ff;
   logic                          s2_frame_last_ff;

   logic                          s1_load;
   logic                          s2_load;
   logic [mmd_pkg::SAMPLE_W-1:0]  pick_value;
   logic [mmd_pkg::MUL_W-1:0]     prod_in;
   logic [SUM_W-1:0]              sum;
   logic [Q_W-1:0]                q;

   // flow control from the output register back to the pair register
   assign s2_load    = s1_valid_ff && (!s2_valid_ff || out_ready);
   assign s1_load    = full_ff && (!s1_valid_ff || s2_load);
   assign pair_ready = !full_ff || (half_ff && s1_load);

   // pick the point and scale it
   assign pick_value = half_ff ? pair_ff.second_value : pair_ff.first_value;
   assign prod_in    = mmd_pkg::MUL_W'(pick_value) * mmd_pkg::MUL_W'(y_gain);

   // offset, floor shift and saturation
   always_comb begin
      sum = {{(SUM_W - mmd_pkg::YCFG_W - 8){y_base[mmd_pkg::YCFG_W-1]}}, y_base, 8'h00}
            + {2'b00, s1_prod_ff};
      q   = sum[SUM_W-1:16];
      if (!q[Q_W-1] && (|q[Q_W-2:mmd_pkg::YPOS_W-1])) begin
         s2_y_in = {1'b0, {(mmd_pkg::YPOS_W-1){1'b1}}};
      end else if (q[Q_W-1] && !(&q[Q_W-2:mmd_pkg::YPOS_W-1])) begin
         s2_y_in = {1'b1, {(mmd_pkg::YPOS_W-1){1'b0}}};
      end else begin
         s2_y_in = q[mmd_pkg::YPOS_W-1:0];
      end
   end

   // pair register and serializer control
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff     <= 1'b0;
         half_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            half_ff <= !half_ff;
            if (half_ff) begin
               full_ff <= 1'b0;
            end
         end
         if (pair_valid) begin
            full_ff <= 1'b1;
            half_ff <= 1'b0;
         end
         if (s1_load) begin
            s1_valid_ff <= 1'b1;
         end else if (s2_load) begin
            s1_valid_ff <= 1'b0;
         end
         if (s2_load) begin
            s2_valid_ff <= 1'b1;
         end else if (out_ready) begin
            s2_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (pair_valid) begin
         pair_ff <= pair;
      end
      if (s1_load) begin
         s1_prod_ff       <= prod_in;
         s1_column_ff     <= pair_ff.column;
         s1_pair_last_ff  <= half_ff;
         s1_frame_last_ff <= half_ff && pair_ff.last;
      end
      if (s2_load) begin
         s2_column_ff     <= s1_column_ff;
         s2_y_ff          <= s2_y_in;
         s2_pair_last_ff  <= s1_pair_last_ff;
         s2_frame_last_ff <= s1_frame_last_ff;
      end
   end

   assign out_valid      = s2_valid_ff;
   assign out_column     = s2_column_ff;
   assign out_y_pos      = s2_y_ff;
   assign out_pair_last  = s2_pair_last_ff;
   assign out_frame_last = s2_frame_last_ff;

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// testbench for min_max_decimator_core: directed and random sample streams with random
// idling on both sides, every point checked against a cycle-free predictor of the column pairs
// depends on mmd_pkg and min_max_decimator_core

module tb;

   // cycles with no handshake at all before the run is declared hung
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 1100;

   typedef struct {
      logic [mmd_pkg::COLUMN_W-1:0]      column;
      logic signed [mmd_pkg::YPOS_W-1:0] y_pos;
      logic                              pair_last;
      logic                              frame_last;
   } point_type;

   // tracks min/max per column and predicts the emitted point pairs
   class column_pair_predictor;
      int errors;
      point_type points_due[$];
      logic [mmd_pkg::SCOUNT_W-1:0]      trace_len;
      logic [mmd_pkg::CCOUNT_W-1:0]      width_cols;
      logic signed [mmd_pkg::YCFG_W-1:0] base;
      logic [mmd_pkg::YCFG_W-1:0]        gain;
      logic [mmd_pkg::SCOUNT_W-1:0]      pos;
      logic [mmd_pkg::COLUMN_W-1:0]      col;
      logic [mmd_pkg::PROD_W-1:0]        pos_weight;   // (pos + 1) * columns
      logic [mmd_pkg::PROD_W-1:0]        col_edge;     // (col + 1) * samples
      logic [mmd_pkg::SAMPLE_W-1:0]      top, bottom;
      logic [mmd_pkg::SCOUNT_W-1:0]      top_at, bottom_at;

      function new();
         errors     = 0;
         trace_len  = mmd_pkg::SAMPLE_COUNT_RST;
         width_cols = mmd_pkg::COLUMN_COUNT_RST;
         base       = '0;
         gain       = '0;
         restart();
      endfunction

      function logic [mmd_pkg::PROD_W-1:0] samples_used();
         int n;
         n = trace_len;
         if (n < 1) n = 1;
         if (n > mmd_pkg::MAX_SAMPLES) n = mmd_pkg::MAX_SAMPLES;
         return mmd_pkg::PROD_W'(n);
      endfunction

      // column count clamped so every column holds at least one sample
      function logic [mmd_pkg::PROD_W-1:0] columns_used();
         int c;
         int n;
         n = samples_used();
         c = width_cols;
         if (c < 1) c = 1;
         if (c > mmd_pkg::MAX_COLUMNS) c = mmd_pkg::MAX_COLUMNS;
         if (c > n) c = n;
         return mmd_pkg::PROD_W'(c);
      endfunction

      function void restart();
         pos        = '0;
         col        = '0;
         pos_weight = columns_used();
         col_edge   = samples_used();
         top        = '0;
         bottom     = '0;
         top_at     = '0;
         bottom_at  = '0;
      endfunction

      function void write_reg(logic [1:0] index, logic [mmd_pkg::YCFG_W-1:0] value);
         case (index)
            mmd_pkg::REG_SAMPLE_COUNT: begin
               trace_len = value[mmd_pkg::SCOUNT_W-1:0];
               restart();
            end
            mmd_pkg::REG_COLUMN_COUNT: begin
               width_cols = value[mmd_pkg::CCOUNT_W-1:0];
               restart();
            end
            mmd_pkg::REG_Y_BASE: base = value;
            mmd_pkg::REG_Y_GAIN: gain = value;
            default: ;
         endcase
      endfunction

      // floor of the scaled sum, saturated to the signed 16 bit range
      function logic signed [mmd_pkg::YPOS_W-1:0] to_pixel(logic [mmd_pkg::SAMPLE_W-1:0] v);
         longint acc;
         acc = longint'(base) * 256 + longint'(v) * longint'(gain);
         acc = acc >>> 16;
         if (acc > 32767) acc = 32767;
         else if (acc < -32768) acc = -32768;
         return mmd_pkg::YPOS_W'(acc);
      endfunction

      function void add_point(logic [mmd_pkg::SAMPLE_W-1:0] v, logic second, logic closing);
         point_type p;
         p.column     = col;
         p.y_pos      = to_pixel(v);
         p.pair_last  = second;
         p.frame_last = second && closing;
         points_due.push_back(p);
      endfunction

      function void take_sample(logic [mmd_pkg::SAMPLE_W-1:0] v);
         logic [mmd_pkg::PROD_W-1:0] n;
         logic [mmd_pkg::PROD_W-1:0] w;
         logic                       closing;
         n = samples_used();
         w = columns_used();
         // first sample of a column opens both extremes
         if ((pos_weight - w) >= (col_edge - n)) begin
            top       = v;
            bottom    = v;
            top_at    = pos;
            bottom_at = pos;
         end else if (v > top) begin
            top    = v;
            top_at = pos;
         end else if (v < bottom) begin
            bottom    = v;
            bottom_at = pos;
         end
         // column end: emit both points in order of occurrence
         if (pos_weight >= col_edge) begin
            closing = (mmd_pkg::PROD_W'(col) + 1 >= w);
            if (bottom_at < top_at) begin
               add_point(bottom, 1'b0, closing);
               add_point(top, 1'b1, closing);
            end else begin
               add_point(top, 1'b0, closing);
               add_point(bottom, 1'b1, closing);
            end
            if (closing) begin
               restart();
               return;
            end
            col      = col + 1'b1;
            col_edge = col_edge + n;
         end
         pos        = pos + 1'b1;
         pos_weight = pos_weight + w;
      endfunction

      function void compare_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_point(logic [mmd_pkg::RSP_DATA_W-1:0] data, logic pair_flag,
                                logic frame_flag);
         point_type due;
         if (points_due.size() == 0) begin
            $error("point with none expected: column %0d", data[mmd_pkg::COLUMN_W-1:0]);
            errors++;
            return;
         end
         due = points_due.pop_front();
         compare_field("column", due.column, data[mmd_pkg::COLUMN_W-1:0]);
         compare_field("y_pos", due.y_pos,
                       $signed(data[mmd_pkg::COLUMN_W +: mmd_pkg::YPOS_W]));
         compare_field("pair_last", due.pair_last, pair_flag);
         compare_field("frame_last", due.frame_last, frame_flag);
         compare_field("tdata padding", 0,
                       data[mmd_pkg::RSP_DATA_W-1:mmd_pkg::COLUMN_W+mmd_pkg::YPOS_W]);
      endfunction

      function int pending();
         return points_due.size();
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [mmd_pkg::SAMPLE_W-1:0]   req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [mmd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;
   logic                           rsp_tlast;
   logic                           csr_we;
   logic [1:0]                     csr_addr;
   logic [mmd_pkg::YCFG_W-1:0]     csr_wdata;

   column_pair_predictor pairs = new();
   bit sender_steady = 1'b0;
   bit rsp_calm      = 1'b0;
   bit hold_request  = 1'b0;
   int idle_cycles   = 0;

   min_max_decimator_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hang detection: no item moving on either side for too long
   always @(negedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin : rsp_side
      int wait_cycles;
      logic [mmd_pkg::RSP_DATA_W-1:0] data;
      logic pair_flag;
      logic frame_flag;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         wait_cycles = rsp_calm ? 0 : $urandom_range(0, 9);
         if (hold_request) begin
            hold_request = 1'b0;
            wait_cycles  = wait_cycles + HOLD_CYCLES;
         end
         if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (!rsp_tvalid);
         data       = rsp_tdata;
         pair_flag  = rsp_tuser;
         frame_flag = rsp_tlast;
         @(posedge clock);
         pairs.check_point(data, pair_flag, frame_flag);
      end
   end

   task automatic send_sample(input logic [mmd_pkg::SAMPLE_W-1:0] value);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      pairs.take_sample(value);
   endtask

   task automatic write_reg(input logic [1:0] index,
                            input logic [mmd_pkg::YCFG_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      pairs.write_reg(index, value);
   endtask

   task automatic configure(input int n, input int w,
                            input logic [mmd_pkg::YCFG_W-1:0] y_off,
                            input logic [mmd_pkg::YCFG_W-1:0] y_scale);
      write_reg(mmd_pkg::REG_SAMPLE_COUNT, mmd_pkg::YCFG_W'(n));
      write_reg(mmd_pkg::REG_COLUMN_COUNT, mmd_pkg::YCFG_W'(w));
      write_reg(mmd_pkg::REG_Y_BASE, y_off);
      write_reg(mmd_pkg::REG_Y_GAIN, y_scale);
   endtask

   // stop offering and let every expected point come out, plus pipeline slack
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pairs.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(output int sent);
      int n;
      int w;
      int count;
      int mode;
      logic [mmd_pkg::SAMPLE_W-1:0] level;
      logic [mmd_pkg::SAMPLE_W-1:0] value;
      logic [mmd_pkg::YCFG_W-1:0]   y_off;
      logic [mmd_pkg::YCFG_W-1:0]   y_scale;
      // sizes: mostly short traces, now and then the largest ones, partly fed
      case ($urandom_range(0, 9))
         0: begin
            n = mmd_pkg::MAX_SAMPLES;
            w = ($urandom_range(0, 1) == 1) ? mmd_pkg::MAX_COLUMNS
                                            : $urandom_range(1, mmd_pkg::MAX_COLUMNS);
            count = $urandom_range(40, 200);
         end
         1: begin
            n = $urandom_range(1, mmd_pkg::MAX_SAMPLES);
            w = $urandom_range(1, mmd_pkg::MAX_COLUMNS);
            count = $urandom_range(40, 200);
         end
         2: begin
            n = 1;
            w = $urandom_range(1, mmd_pkg::MAX_COLUMNS);
            count = $urandom_range(10, 30);
         end
         default: begin
            n = $urandom_range(1, 48);
            w = $urandom_range(1, n + 4);
            count = n * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) count += $urandom_range(0, n - 1);
         end
      endcase
      case ($urandom_range(0, 2))
         0: y_off = mmd_pkg::YCFG_W'($urandom_range(0, 1 << 20)) - mmd_pkg::YCFG_W'(1 << 19);
         1: y_off = mmd_pkg::YCFG_W'($urandom);
         default: y_off = ($urandom_range(0, 1) == 1) ? 24'h800000 : 24'h7FFFFF;
      endcase
      case ($urandom_range(0, 3))
         0: y_scale = mmd_pkg::YCFG_W'($urandom_range(0, 32767));
         1: y_scale = mmd_pkg::YCFG_W'($urandom_range(0, 1 << 18));
         2: y_scale = mmd_pkg::YCFG_W'($urandom);
         default: y_scale = ($urandom_range(0, 1) == 1) ? 24'hFFFFFF : 24'h000000;
      endcase
      mode          = $urandom_range(0, 3);
      level         = mmd_pkg::SAMPLE_W'($urandom);
      sender_steady = ($urandom_range(0, 3) == 0);
      configure(n, w, y_off, y_scale);
      for (int i = 0; i < count; i++) begin
         case (mode)
            0: value = mmd_pkg::SAMPLE_W'($urandom);
            1: value = level + mmd_pkg::SAMPLE_W'($urandom_range(0, 3));   // narrow band, many ties
            2: value = ($urandom_range(0, 1) == 1) ? '1 : '0;
            default: value = level;                                        // flat trace
         endcase
         send_sample(value);
      end
      drain();
      sent = count;
   endtask

   initial begin : stimulus
      int random_items;
      int sent;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = mmd_pkg::REG_SAMPLE_COUNT;
      csr_wdata  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // two columns of unequal width, unit gain saturating at the top
      configure(5, 2, 24'h000000, 24'h010000);
      send_sample(16'd65535);
      send_sample(16'd0);
      send_sample(16'd7);
      send_sample(16'd7);
      send_sample(16'd3);
      drain();

      // more columns asked than samples: one sample per column, full scale mapping
      configure(3, 9, 24'h800000, 24'hFFFFFF);
      send_sample(16'd0);
      send_sample(16'd65535);
      send_sample(16'd100);
      drain();

      // one column spanning the trace, min ahead of max, ties ignored
      configure(4, 1, 24'h7FFFFF, 24'h000000);
      send_sample(16'd10);
      send_sample(16'd5);
      send_sample(16'd20);
      send_sample(16'd20);
      drain();

      // size write in the middle of a trace restarts it; negative offset floors
      send_sample(16'd1);
      send_sample(16'd2);
      drain();
      configure(2, 1, 24'hFFFFFF, 24'h000001);
      send_sample(16'd0);
      send_sample(16'd300);
      drain();

      // backpressure: every sample closes a column while the result side holds off
      random_items  = 0;
      configure(64, 64, 24'h000100, 24'h008000);
      sender_steady = 1'b1;
      hold_request  = 1'b1;
      for (int i = 0; i < 128; i++) send_sample(mmd_pkg::SAMPLE_W'($urandom));
      drain();
      random_items += 128;

      while (random_items < RANDOM_ITEMS) begin
         random_phase(sent);
         random_items += sent;
      end

      if (pairs.errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
